// File: src/q2e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, types and the arctangent table for the quaternion to Euler
// angle unit.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CordicStagesDef = 16;

  localparam int QW      = 16;  // quaternion component width
  localparam int PROD_W  = 32;  // Q4.28 product
  localparam int SUM_W   = 34;  // doubled sum of products
  localparam int S_W     = 30;  // saturated asin argument
  localparam int CW      = 44;  // CORDIC vector width
  localparam int AW      = 34;  // binary angle width, 2^32 per turn
  localparam int SQ_W    = 58;  // square root radicand
  localparam int RT_W    = 29;  // square root result
  localparam int SQRT_CELLS = RT_W;
  localparam int PRE_SHIFT  = 8;
  localparam int OW      = 16;  // roll and yaw width
  localparam int PW      = 15;  // pitch width

  localparam logic signed [AW-1:0]    ANGLE_QUARTER = 34'sd1073741824;
  localparam logic signed [SUM_W-1:0] UNIT_Q28      = 34'sd268435456;
  localparam logic [SQ_W-1:0]         UNIT_SQ       = 58'd72057594037927936;
  localparam int RollLimit  = 23040;
  localparam int PitchLimit = 11520;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [AW-1:0] ang;
    logic                 zero;
  } cvec_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rn;
    logic signed [SUM_W-1:0] rd;
    logic signed [SUM_W-1:0] yn;
    logic signed [SUM_W-1:0] yd;
    logic signed [S_W-1:0]   s;
  } carry_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: src/q2e_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One result bit of the digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell import q2e_pkg::*; #(
  parameter int K = 0
) (
  input  wire logic            clk,
  input  wire logic [SQ_W-1:0] rem_in,
  input  wire logic [RT_W-1:0] root_in,
  input  wire carry_t          carry_in,
  output      logic [SQ_W-1:0] rem_out,
  output      logic [RT_W-1:0] root_out,
  output      carry_t          carry_out
);

  logic [SQ_W+1:0] trial;

  // trial = (2*root + 2^K) * 2^K
  assign trial = ({{(SQ_W+2-RT_W){1'b0}}, root_in} << (K+1))
               + ((SQ_W+2)'(1) << (2*K));

  always_ff @(posedge clk) begin
    if ({2'b00, rem_in} >= trial) begin
      rem_out  <= rem_in - trial[SQ_W-1:0];
      root_out <= root_in | (RT_W'(1) << K);
    end else begin
      rem_out  <= rem_in;
      root_out <= root_in;
    end
    carry_out <= carry_in;
  end

endmodule
`default_nettype wire

// File: src/q2e_prerot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_prerot
// Quarter-turn pre-rotation into the right half-plane; marks a zero vector.
// ----------------------------------------------------------------------------
module q2e_prerot import q2e_pkg::*; (
  input  wire logic                 clk,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  output      cvec_t                vec_out
);

  always_ff @(posedge clk) begin
    vec_out.zero <= (x_in == '0) && (y_in == '0);
    if (x_in[CW-1]) begin
      if (!y_in[CW-1]) begin
        vec_out.x   <= y_in;
        vec_out.y   <= -x_in;
        vec_out.ang <= ANGLE_QUARTER;
      end else begin
        vec_out.x   <= -y_in;
        vec_out.y   <= x_in;
        vec_out.ang <= -ANGLE_QUARTER;
      end
    end else begin
      vec_out.x   <= x_in;
      vec_out.y   <= y_in;
      vec_out.ang <= '0;
    end
  end

endmodule
`default_nettype wire

// File: src/q2e_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, driving y toward zero.
// ----------------------------------------------------------------------------
module q2e_cordic_cell import q2e_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic  clk,
  input  wire cvec_t vec_in,
  output      cvec_t vec_out
);

  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic signed [AW-1:0] step;

  assign sx   = vec_in.x >>> STAGE;
  assign sy   = vec_in.y >>> STAGE;
  assign step = signed'({2'b00, atan_entry(5'(STAGE))});

  always_ff @(posedge clk) begin
    vec_out.zero <= vec_in.zero;
    if (!vec_in.y[CW-1]) begin
      vec_out.x   <= vec_in.x + sy;
      vec_out.y   <= vec_in.y - sx;
      vec_out.ang <= vec_in.ang + step;
    end else begin
      vec_out.x   <= vec_in.x - sy;
      vec_out.y   <= vec_in.y + sx;
      vec_out.ang <= vec_in.ang - step;
    end
  end

endmodule
`default_nettype wire

// File: src/q2e_deg_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// q2e_deg_conv
// Binary angle to 1/128 degree, rounded half away from zero, saturated.
// ----------------------------------------------------------------------------
module q2e_deg_conv import q2e_pkg::*; #(
  parameter int LIMIT = RollLimit,
  parameter int OUT_W = OW
) (
  input  wire logic                    clk,
  input  wire cvec_t                   vec_in,
  output      logic signed [OUT_W-1:0] deg
);

  logic signed [AW-1:0] ang;
  logic [AW-1:0]        mag;
  logic [AW+5:0]        prod;
  logic                 neg;
  logic [AW+5:0]        rounded;
  logic [16:0]          r;
  logic [16:0]          r_sat;

  assign ang = vec_in.zero ? '0 : vec_in.ang;
  assign mag = ang[AW-1] ? AW'(-ang) : AW'(ang);

  always_ff @(posedge clk) begin
    prod <= {6'b0, mag} * (AW+6)'(45);
    neg  <= ang[AW-1];
  end

  always_comb begin
    rounded = (prod + (AW+6)'(2097152)) >> 22;
    r       = rounded[16:0];
    r_sat   = (r > 17'(LIMIT)) ? 17'(LIMIT) : r;
  end

  always_ff @(posedge clk) begin
    deg <= neg ? OUT_W'(-r_sat) : OUT_W'(r_sat);
  end

endmodule
`default_nettype wire

// File: src/quaternion_to_euler_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit
// Q2.14 quaternion to roll, pitch and yaw in 1/128 degree.
// ----------------------------------------------------------------------------
// The unit takes one quaternion in every clock cycle (busy is always low) and
// returns its angles with done high once they pass the product, sum and
// squared-argument registers, one cell per result bit of the 29-bit square
// root for the pitch cosine, a pre-rotation register, one CORDIC cell per
// stage, and the product and output registers of the degree conversion.
// Results are not held; the receiver must take them in the cycle done is high.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit import q2e_pkg::*; #(
  parameter int CORDIC_STAGES = CordicStagesDef
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire logic signed [QW-1:0] quat_w,
  input  wire logic signed [QW-1:0] quat_x,
  input  wire logic signed [QW-1:0] quat_y,
  input  wire logic signed [QW-1:0] quat_z,
  output      logic                 done,
  output      logic signed [OW-1:0] roll_angle,
  output      logic signed [PW-1:0] pitch_angle,
  output      logic signed [OW-1:0] yaw_angle,
  output      logic                 pitch_clamped
);

  localparam int LAT     = 3 + SQRT_CELLS + 1 + CORDIC_STAGES + 2;
  localparam int FLAG_D  = CORDIC_STAGES + 3;
  localparam int EXT_SUM = CW - SUM_W - PRE_SHIFT;
  localparam int EXT_S   = CW - S_W - PRE_SHIFT;
  localparam int EXT_RT  = CW - RT_W - PRE_SHIFT;

  logic [LAT-1:0] vld;

  logic signed [PROD_W-1:0] p_ww, p_xx, p_yy, p_zz, p_yz, p_xw, p_xy, p_zw, p_yw, p_xz;
  carry_t                   sums;
  logic                     clamp;
  carry_t                   carry3;
  logic                     clamp3;
  logic [SQ_W-1:0]          ss;
  logic signed [SUM_W-1:0]  s_raw;
  logic [RT_W-1:0]          s_mag;

  assign busy = 1'b0;

  // valid flag travels alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end
  assign done = vld[LAT-1];

  always_ff @(posedge clk) begin
    p_ww <= quat_w * quat_w;
    p_xx <= quat_x * quat_x;
    p_yy <= quat_y * quat_y;
    p_zz <= quat_z * quat_z;
    p_yz <= quat_y * quat_z;
    p_xw <= quat_x * quat_w;
    p_xy <= quat_x * quat_y;
    p_zw <= quat_z * quat_w;
    p_yw <= quat_y * quat_w;
    p_xz <= quat_x * quat_z;
  end

  assign s_raw = (SUM_W'(p_yw) - SUM_W'(p_xz)) <<< 1;

  always_ff @(posedge clk) begin
    sums.rn <= (SUM_W'(p_yz) + SUM_W'(p_xw)) <<< 1;
    sums.rd <= SUM_W'(p_ww) - SUM_W'(p_xx) - SUM_W'(p_yy) + SUM_W'(p_zz);
    sums.yn <= (SUM_W'(p_xy) + SUM_W'(p_zw)) <<< 1;
    sums.yd <= SUM_W'(p_ww) + SUM_W'(p_xx) - SUM_W'(p_yy) - SUM_W'(p_zz);
    // saturate the asin argument to +-1.0
    if (s_raw > UNIT_Q28) begin
      sums.s <= S_W'(UNIT_Q28);
      clamp  <= 1'b1;
    end else if (s_raw < -UNIT_Q28) begin
      sums.s <= S_W'(-UNIT_Q28);
      clamp  <= 1'b1;
    end else begin
      sums.s <= S_W'(s_raw);
      clamp  <= 1'b0;
    end
  end

  // |s| is at most 2^28, so its magnitude fits the root width
  assign s_mag = sums.s[S_W-1] ? RT_W'(-sums.s) : RT_W'(sums.s);

  always_ff @(posedge clk) begin
    ss     <= s_mag * s_mag;
    carry3 <= sums;
    clamp3 <= clamp;
  end

  // square root chain
  logic [SQ_W-1:0] rem_c  [SQRT_CELLS+1];
  logic [RT_W-1:0] root_c [SQRT_CELLS+1];
  carry_t          car_c  [SQRT_CELLS+1];

  assign rem_c[0]  = UNIT_SQ - ss;
  assign root_c[0] = '0;
  assign car_c[0]  = carry3;

  for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
    q2e_sqrt_cell #(.K(SQRT_CELLS - 1 - i)) u_cell (
      .clk       (clk),
      .rem_in    (rem_c[i]),
      .root_in   (root_c[i]),
      .carry_in  (car_c[i]),
      .rem_out   (rem_c[i+1]),
      .root_out  (root_c[i+1]),
      .carry_out (car_c[i+1])
    );
  end

  // clamp flag waits for the sqrt chain, then for pre-rotation, CORDIC, conversion
  logic [SQRT_CELLS-1:0] clamp_sq;
  logic [FLAG_D-1:0]     clamp_d;

  always_ff @(posedge clk) begin
    clamp_sq <= {clamp_sq[SQRT_CELLS-2:0], clamp3};
    clamp_d  <= {clamp_d[FLAG_D-2:0], clamp_sq[SQRT_CELLS-1]};
  end

  carry_t               cq;
  logic signed [CW-1:0] xin [3];
  logic signed [CW-1:0] yin [3];

  assign cq     = car_c[SQRT_CELLS];
  assign yin[0] = {{EXT_SUM{cq.rn[SUM_W-1]}}, cq.rn, {PRE_SHIFT{1'b0}}};
  assign xin[0] = {{EXT_SUM{cq.rd[SUM_W-1]}}, cq.rd, {PRE_SHIFT{1'b0}}};
  assign yin[1] = {{EXT_S{cq.s[S_W-1]}}, cq.s, {PRE_SHIFT{1'b0}}};
  assign xin[1] = {{EXT_RT{1'b0}}, root_c[SQRT_CELLS], {PRE_SHIFT{1'b0}}};
  assign yin[2] = {{EXT_SUM{cq.yn[SUM_W-1]}}, cq.yn, {PRE_SHIFT{1'b0}}};
  assign xin[2] = {{EXT_SUM{cq.yd[SUM_W-1]}}, cq.yd, {PRE_SHIFT{1'b0}}};

  cvec_t chain [3][CORDIC_STAGES+1];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    q2e_prerot u_pre (
      .clk     (clk),
      .x_in    (xin[c]),
      .y_in    (yin[c]),
      .vec_out (chain[c][0])
    );
    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_stage
      q2e_cordic_cell #(.STAGE(j)) u_cell (
        .clk     (clk),
        .vec_in  (chain[c][j]),
        .vec_out (chain[c][j+1])
      );
    end
  end

  q2e_deg_conv #(.LIMIT(RollLimit), .OUT_W(OW)) u_roll (
    .clk (clk), .vec_in (chain[0][CORDIC_STAGES]), .deg (roll_angle)
  );
  q2e_deg_conv #(.LIMIT(PitchLimit), .OUT_W(PW)) u_pitch (
    .clk (clk), .vec_in (chain[1][CORDIC_STAGES]), .deg (pitch_angle)
  );
  q2e_deg_conv #(.LIMIT(RollLimit), .OUT_W(OW)) u_yaw (
    .clk (clk), .vec_in (chain[2][CORDIC_STAGES]), .deg (yaw_angle)
  );

  assign pitch_clamped = clamp_d[FLAG_D-1];

endmodule
`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives quaternions into quaternion_to_euler_unit with a start/busy request
// handshake and checks every done strobe against a fixed point CORDIC
// predictor of roll, pitch and yaw.
// ----------------------------------------------------------------------------
module tb_top;
  import q2e_pkg::*;

  localparam int Stages   = CordicStagesDef;
  localparam int Latency  = 35 + Stages;
  localparam int CycleCap = 400000;

  typedef struct {
    logic signed [OW-1:0] roll;
    logic signed [PW-1:0] pitch;
    logic signed [OW-1:0] yaw;
    logic                 clamp;
  } angles_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [QW-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
  logic done;
  logic signed [OW-1:0] roll_angle, yaw_angle;
  logic signed [PW-1:0] pitch_angle;
  logic pitch_clamped;

  angles_t angle_fifo[$];
  int mismatches = 0;
  int idle_pct = 0;
  int cycles = 0;

  quaternion_to_euler_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle), .pitch_clamped(pitch_clamped)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint atan_table(int i);
    return longint'(atan_entry(i[4:0]));
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint ang, nx, ny, sx, sy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; ang = 64'sd1073741824;
      end else begin
        nx = -y; ny = x; ang = -64'sd1073741824;
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < Stages && i < 32; i++) begin
      sx = shr(x, i);
      sy = shr(y, i);
      if (y >= 0) begin
        x = x + sy; y = y - sx; ang += atan_table(i);
      end else begin
        x = x - sy; y = y + sx; ang -= atan_table(i);
      end
    end
    return ang;
  endfunction

  function automatic longint to_deg128(longint ang, longint limit);
    logic neg;
    longint unsigned m;
    longint r;
    neg = ang < 0;
    m = longint'(neg ? -ang : ang) * 45;
    r = longint'((m + 64'd2097152) >> 22);
    if (r > limit) r = limit;
    return neg ? -r : r;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
    angles_t a;
    longint rn, rd, yn, yd, s, c, unit;
    unit = 64'sd268435456;
    rn = 2 * (y * z + x * w);
    rd = w * w - x * x - y * y + z * z;
    yn = 2 * (x * y + z * w);
    yd = w * w + x * x - y * y - z * z;
    s = 2 * (y * w - x * z);
    a.clamp = 1'b0;
    if (s > unit) begin
      s = unit; a.clamp = 1'b1;
    end else if (s < -unit) begin
      s = -unit; a.clamp = 1'b1;
    end
    c = longint'(int_sqrt(longint'(unit * unit - s * s)));
    a.roll  = OW'(to_deg128(vector_angle(rn * 256, rd * 256), RollLimit));
    a.pitch = PW'(to_deg128(vector_angle(s * 256, c * 256), PitchLimit));
    a.yaw   = OW'(to_deg128(vector_angle(yn * 256, yd * 256), RollLimit));
    return a;
  endfunction

  // start stays high after a request; idling or draining drops it
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    angle_fifo = {angle_fifo, euler_of(longint'($signed(w)), longint'($signed(x)),
                                       longint'($signed(y)), longint'($signed(z)))};
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (angle_fifo.size() != 0) @(posedge clk);
  endtask

  // Expectation is queued after the accepting edge, before done can rise.
  always @(posedge clk) begin
    angles_t e;
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (angle_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        e = angle_fifo.pop_front();
        if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
            e.yaw !== yaw_angle || e.clamp !== pitch_clamped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %b got %0d %0d %0d %b",
                     e.roll, e.pitch, e.yaw, e.clamp,
                     roll_angle, pitch_angle, yaw_angle, pitch_clamped);
        end
      end
    end
  end

  task automatic test_directed();
    logic [15:0] ext[6];
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
    send_quat(16'h4000, '0, '0, '0);
    send_quat('0, '0, '0, '0);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_quat(16'h2D41, '0, 16'h2D41, '0);   // pitch just below the pole
    send_quat(16'h2D41, '0, 16'hD2BF, '0);
    send_quat(16'h4000, '0, 16'h4000, '0);   // non-normalized, clamp high
    send_quat(16'h4000, '0, 16'hC000, '0);   // clamp low
    send_quat('0, 16'h4000, '0, '0);
    send_quat('0, '0, '0, 16'h4000);
    send_quat('0, '0, 16'h4000, '0);
    send_quat(16'hC000, '0, '0, '0);
    for (int i = 0; i < 12; i++)
      send_quat(ext[$urandom_range(5, 0)], ext[$urandom_range(5, 0)],
                ext[$urandom_range(5, 0)], ext[$urandom_range(5, 0)]);
  endtask

  task automatic test_random(int n, int pct);
    logic [15:0] q[4];
    idle_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3, 0) != 0) begin
        // mostly bounded: components within +-1.0
        for (int k = 0; k < 4; k++) q[k] = 16'($signed($urandom_range(16384, 0)) -
                                               (($urandom_range(1, 0)) ? 0 : 16384));
      end else begin
        for (int k = 0; k < 4; k++) q[k] = 16'($urandom);
      end
      send_quat(q[0], q[1], q[2], q[3]);
    end
    idle_pct = 0;
  endtask

  task automatic test_pause();
    send_quat(16'h1234, 16'h0567, 16'hF00D, 16'h2222);
    drain_results();
    repeat (Latency) @(posedge clk);
    send_quat(16'h3000, 16'hE000, 16'h1000, 16'h0800);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0);
    test_random(200, 73);
    test_pause();
    test_random(200, 73);
    test_random(200, 19);
    drain_results();
    repeat (Latency + 4) @(posedge clk);
    if (mismatches == 0 && angle_fifo.size() == 0)
      $display("quaternion_to_euler_unit verification clean");
    else
      $display("quaternion_to_euler_unit verification failed");
    $finish;
  end

  initial begin
    wait (cycles >= CycleCap);
    $display("quaternion_to_euler_unit verification failed");
    $finish;
  end
endmodule

// File: files.f
src/q2e_pkg.sv
src/q2e_sqrt_cell.sv
src/q2e_prerot.sv
src/q2e_cordic_cell.sv
src/q2e_deg_conv.sv
src/quaternion_to_euler_unit.sv
test/tb_top.sv
